// ===== src/elx_pkg.sv =====
// shared types, character codes and token start decode for the expression lexer
`default_nettype none

package elx_pkg;

  localparam int LENGTH_BITS_DEF = 8;
  localparam int OQ_DEPTH        = 4;
  localparam int OQ_PTR_W        = $clog2(OQ_DEPTH);
  localparam int OQ_CNT_W        = $clog2(OQ_DEPTH + 1);

  typedef enum logic [4:0] {
    K_EOF     = 5'd0,
    K_COMMA   = 5'd1,
    K_LPAREN  = 5'd2,
    K_RPAREN  = 5'd3,
    K_SEMI    = 5'd4,
    K_PLUS    = 5'd5,
    K_MINUS   = 5'd6,
    K_STAR    = 5'd7,
    K_SLASH   = 5'd8,
    K_GT      = 5'd9,
    K_GE      = 5'd10,
    K_LT      = 5'd11,
    K_LE      = 5'd12,
    K_ASSIGN  = 5'd13,
    K_EQ      = 5'd14,
    K_NE      = 5'd15,
    K_UNKNOWN = 5'd16,
    K_NUMBER  = 5'd17,
    K_IDENT   = 5'd18
  } kind_t;

  typedef enum logic [7:0] {
    M_IDLE    = 8'b0000_0001,
    M_COMMENT = 8'b0000_0010,
    M_GT      = 8'b0000_0100,
    M_LT      = 8'b0000_1000,
    M_EQ      = 8'b0001_0000,
    M_BANG    = 8'b0010_0000,
    M_NUMBER  = 8'b0100_0000,
    M_IDENT   = 8'b1000_0000
  } mode_t;

  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_SEMI   = 8'h3B;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_HASH   = 8'h23;
  localparam logic [7:0] CH_NL     = 8'h0A;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_EQ     = 8'h3D;
  localparam logic [7:0] CH_BANG   = 8'h21;
  localparam logic [7:0] CH_POINT  = 8'h2E;
  localparam logic [7:0] CH_GT     = 8'h3E;
  localparam logic [7:0] CH_LT     = 8'h3C;

  typedef struct packed {
    logic [7:0] ch;
    logic       is_end;
  } in_t;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] length;
    logic       last;
  } out_t;

  // decoded effect of a byte seen with no token pending
  typedef struct packed {
    mode_t mode;
    logic  begins_len;
    logic  emits;
    kind_t kind;
  } start_t;

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= 8'h30) && (c <= 8'h39);
  endfunction

  function automatic logic is_letter(input logic [7:0] c);
    return ((c >= 8'h41) && (c <= 8'h5A)) || ((c >= 8'h61) && (c <= 8'h7A));
  endfunction

  function automatic start_t start_token(input logic [7:0] c);
    start_t s;
    s.mode       = M_IDLE;
    s.begins_len = 1'b0;
    s.emits      = 1'b0;
    s.kind       = K_UNKNOWN;
    case (c)
      CH_COMMA:  begin s.emits = 1'b1; s.kind = K_COMMA;  end
      CH_LPAREN: begin s.emits = 1'b1; s.kind = K_LPAREN; end
      CH_RPAREN: begin s.emits = 1'b1; s.kind = K_RPAREN; end
      CH_SEMI:   begin s.emits = 1'b1; s.kind = K_SEMI;   end
      CH_PLUS:   begin s.emits = 1'b1; s.kind = K_PLUS;   end
      CH_MINUS:  begin s.emits = 1'b1; s.kind = K_MINUS;  end
      CH_STAR:   begin s.emits = 1'b1; s.kind = K_STAR;   end
      CH_SLASH:  begin s.emits = 1'b1; s.kind = K_SLASH;  end
      CH_HASH:   s.mode = M_COMMENT;
      CH_NL:     s.mode = M_IDLE;
      CH_SPACE:  s.mode = M_IDLE;
      CH_GT:     s.mode = M_GT;
      CH_LT:     s.mode = M_LT;
      CH_EQ:     s.mode = M_EQ;
      CH_BANG:   s.mode = M_BANG;
      default: begin
        if (is_digit(c)) begin
          s.mode       = M_NUMBER;
          s.begins_len = 1'b1;
        end else if (is_letter(c)) begin
          s.mode       = M_IDENT;
          s.begins_len = 1'b1;
        end else begin
          s.emits = 1'b1;
          s.kind  = K_UNKNOWN;
        end
      end
    endcase
    return s;
  endfunction

endpackage

`default_nettype wire

// ===== src/expression_language_lexer.sv =====
// expression lexer top level: scan state, token decode and result queue
// results of a byte are registered into the result queue and offered on out_ in order
// throughput: one byte per cycle while out_ready is high and each byte yields at most
//   one token; a byte that yields two tokens (a flush plus a new token, a flush plus eof,
//   or a bad number plus a lone point) fills the 4-entry result queue faster than the single result port drains it
// reset: rst_n low clears the scan state to idle and empties the result queue
`default_nettype none

module expression_language_lexer import elx_pkg::*; #(
  parameter int LENGTH_BITS = LENGTH_BITS_DEF
) (
  input  wire      clk,
  input  wire      rst_n,
  input  wire      in_valid,
  output logic     in_ready,
  input  wire in_t in_data,
  output logic     out_valid,
  input  wire      out_ready,
  output out_t     out_data
);

  localparam logic [LENGTH_BITS-1:0] LEN_MAX = {LENGTH_BITS{1'b1}};
  localparam logic [LENGTH_BITS-1:0] LEN_ONE = LENGTH_BITS'(1);

  // scan state
  mode_t                  mode_r, mode_nxt;
  logic [LENGTH_BITS-1:0] tok_len_r, tok_len_nxt;
  logic                   point_r, point_nxt;

  // result queue
  out_t                   q_r [OQ_DEPTH];
  logic [OQ_PTR_W-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [OQ_PTR_W-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [OQ_CNT_W-1:0]    cnt_r, cnt_nxt;

  logic                   in_acc;
  logic                   out_acc;

  // decode of the current byte
  logic [LENGTH_BITS-1:0] len_inc;
  logic [7:0]             len_rep;
  logic [7:0]             inc_rep;
  start_t                 st;
  logic                   flush_v;
  kind_t                  flush_kind;
  logic [7:0]             flush_len;
  kind_t                  cmp_kind;

  kind_t                  res_kind [2];
  logic [7:0]             res_len  [2];
  logic [1:0]             res_n;
  out_t                   res0, res1;
  logic [1:0]             push_n;

  assign in_acc  = in_valid && in_ready;
  assign out_acc = out_valid && out_ready;

  // room for the worst case of two results per byte
  assign in_ready  = (cnt_r <= OQ_CNT_W'(OQ_DEPTH - 2));
  assign out_valid = (cnt_r != '0);
  assign out_data  = q_r[rd_ptr_r];

  // saturating length arithmetic, reported length clipped to eight bits
  assign len_inc = (tok_len_r == LEN_MAX) ? tok_len_r : tok_len_r + LEN_ONE;
  assign len_rep = (32'(tok_len_r) > 32'd255) ? 8'd255 : 8'(tok_len_r);
  assign inc_rep = (32'(len_inc) > 32'd255) ? 8'd255 : 8'(len_inc);

  assign st = start_token(in_data.ch);

  // token left pending by a lookahead mode
  always_comb begin
    flush_v    = 1'b1;
    flush_kind = K_UNKNOWN;
    flush_len  = 8'd1;
    cmp_kind   = K_NE;
    case (mode_r)
      M_GT:     begin flush_kind = K_GT;     cmp_kind = K_GE; end
      M_LT:     begin flush_kind = K_LT;     cmp_kind = K_LE; end
      M_EQ:     begin flush_kind = K_ASSIGN; cmp_kind = K_EQ; end
      M_BANG:   begin flush_kind = K_UNKNOWN; cmp_kind = K_NE; end
      M_NUMBER: begin flush_kind = K_NUMBER; flush_len = len_rep; end
      M_IDENT:  begin flush_kind = K_IDENT;  flush_len = len_rep; end
      default:  flush_v = 1'b0;
    endcase
  end

  // next scan state and the zero to two tokens this byte produces
  always_comb begin
    mode_nxt    = mode_r;
    tok_len_nxt = tok_len_r;
    point_nxt   = point_r;
    res_kind[0] = K_EOF;
    res_kind[1] = K_EOF;
    res_len[0]  = 8'd0;
    res_len[1]  = 8'd0;
    res_n       = 2'd0;

    if (in_data.is_end) begin
      // flush anything pending, then eof; a comment just ends
      if (flush_v) begin
        res_kind[res_n[0]] = flush_kind;
        res_len[res_n[0]]  = flush_len;
        res_n              = res_n + 2'd1;
      end
      res_kind[res_n[0]] = K_EOF;
      res_len[res_n[0]]  = 8'd0;
      res_n              = res_n + 2'd1;
      mode_nxt    = M_IDLE;
      tok_len_nxt = '0;
      point_nxt   = 1'b0;
    end else begin
      case (mode_r)
        M_COMMENT: begin
          if (in_data.ch == CH_NL) begin
            mode_nxt    = M_IDLE;
            tok_len_nxt = '0;
            point_nxt   = 1'b0;
          end
        end
        M_GT, M_LT, M_EQ, M_BANG: begin
          if (in_data.ch == CH_EQ) begin
            // two-character comparison
            res_kind[res_n[0]] = cmp_kind;
            res_len[res_n[0]]  = 8'd2;
            res_n              = res_n + 2'd1;
            mode_nxt    = M_IDLE;
            tok_len_nxt = '0;
            point_nxt   = 1'b0;
          end else begin
            res_kind[res_n[0]] = flush_kind;
            res_len[res_n[0]]  = flush_len;
            res_n              = res_n + 2'd1;
            mode_nxt    = st.mode;
            tok_len_nxt = st.begins_len ? LEN_ONE : '0;
            point_nxt   = 1'b0;
            if (st.emits) begin
              res_kind[res_n[0]] = st.kind;
              res_len[res_n[0]]  = 8'd1;
              res_n              = res_n + 2'd1;
            end
          end
        end
        M_NUMBER: begin
          if (is_digit(in_data.ch)) begin
            tok_len_nxt = len_inc;
          end else if (in_data.ch == CH_POINT && !point_r) begin
            point_nxt   = 1'b1;
            tok_len_nxt = len_inc;
          end else if (in_data.ch == CH_POINT) begin
            // second point: bad number including the point, then a lone point
            res_kind[res_n[0]] = K_UNKNOWN;
            res_len[res_n[0]]  = inc_rep;
            res_n              = res_n + 2'd1;
            res_kind[res_n[0]] = K_UNKNOWN;
            res_len[res_n[0]]  = 8'd1;
            res_n              = res_n + 2'd1;
            mode_nxt    = M_IDLE;
            tok_len_nxt = '0;
            point_nxt   = 1'b0;
          end else begin
            res_kind[res_n[0]] = flush_kind;
            res_len[res_n[0]]  = flush_len;
            res_n              = res_n + 2'd1;
            mode_nxt    = st.mode;
            tok_len_nxt = st.begins_len ? LEN_ONE : '0;
            point_nxt   = 1'b0;
            if (st.emits) begin
              res_kind[res_n[0]] = st.kind;
              res_len[res_n[0]]  = 8'd1;
              res_n              = res_n + 2'd1;
            end
          end
        end
        M_IDENT: begin
          if (is_digit(in_data.ch) || is_letter(in_data.ch)) begin
            tok_len_nxt = len_inc;
          end else begin
            res_kind[res_n[0]] = flush_kind;
            res_len[res_n[0]]  = flush_len;
            res_n              = res_n + 2'd1;
            mode_nxt    = st.mode;
            tok_len_nxt = st.begins_len ? LEN_ONE : '0;
            point_nxt   = 1'b0;
            if (st.emits) begin
              res_kind[res_n[0]] = st.kind;
              res_len[res_n[0]]  = 8'd1;
              res_n              = res_n + 2'd1;
            end
          end
        end
        default: begin
          // idle: byte opens a token or is a one-character token itself
          mode_nxt    = st.mode;
          tok_len_nxt = st.begins_len ? LEN_ONE : '0;
          point_nxt   = 1'b0;
          if (st.emits) begin
            res_kind[res_n[0]] = st.kind;
            res_len[res_n[0]]  = 8'd1;
            res_n              = res_n + 2'd1;
          end
        end
      endcase
    end
  end

  // pack results, marking the last one of this transaction
  always_comb begin
    res0.kind   = res_kind[0];
    res0.length = res_len[0];
    res0.last   = (res_n == 2'd1);
    res1.kind   = res_kind[1];
    res1.length = res_len[1];
    res1.last   = 1'b1;
  end

  assign push_n = in_acc ? res_n : 2'd0;

  assign wr_ptr_nxt = wr_ptr_r + OQ_PTR_W'(push_n);
  assign rd_ptr_nxt = rd_ptr_r + OQ_PTR_W'(out_acc);
  assign cnt_nxt    = cnt_r + OQ_CNT_W'(push_n) - OQ_CNT_W'(out_acc);

  // scan state and queue control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r    <= M_IDLE;
      tok_len_r <= '0;
      point_r   <= 1'b0;
      wr_ptr_r  <= '0;
      rd_ptr_r  <= '0;
      cnt_r     <= '0;
    end else begin
      if (in_acc) begin
        mode_r    <= mode_nxt;
        tok_len_r <= tok_len_nxt;
        point_r   <= point_nxt;
      end
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // queue storage, first result at the write pointer, second right after it
  always_ff @(posedge clk) begin
    if (push_n != 2'd0) begin
      q_r[wr_ptr_r] <= res0;
    end
    if (push_n == 2'd2) begin
      q_r[wr_ptr_r + OQ_PTR_W'(1)] <= res1;
    end
  end

  // queue never overfills
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= OQ_CNT_W'(OQ_DEPTH))
    else $error("result queue overflow");

  // end marker always returns the scanner to idle
  a_end_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && in_data.is_end |=> mode_r == M_IDLE)
    else $error("scanner not idle after end marker");

  // idle scanner carries no length or point
  a_idle_clean: assert property (@(posedge clk) disable iff (!rst_n)
    mode_r == M_IDLE |-> (tok_len_r == '0) && !point_r)
    else $error("stale token state while idle");

  // a pop with no push shrinks the queue by one
  a_pop_only: assert property (@(posedge clk) disable iff (!rst_n)
    out_acc && !in_acc |=> cnt_r == $past(cnt_r) - OQ_CNT_W'(1))
    else $error("queue count wrong after pop");

endmodule

`default_nettype wire
